// ===== hdl/can_command_frame_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// CAN command frame parser assertion macros
// Shared property forms used by the assertions of the parser core.
// ----------------------------------------------------------------------------
`ifndef CAN_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define CAN_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ccfp_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN command frame parser package
// Shared widths, frame layout constants and the parsed command type.
// ----------------------------------------------------------------------------
package ccfp_pkg;

  localparam int CNT_W = 5;
  localparam int OUT_DATA_W = 120;

  localparam logic [7:0] MODE_STD = 8'd0;
  localparam logic [7:0] MODE_EXT = 8'd1;
  localparam logic [7:0] MAX_LEN = 8'd8;

  localparam logic [CNT_W-1:0] CHECK_IDX = 5'd5;
  localparam logic [CNT_W-1:0] STD_BASE = 5'd4;
  localparam logic [CNT_W-1:0] EXT_BASE = 5'd6;
  localparam logic [CNT_W-1:0] STD_TOTAL = 5'd6;
  localparam logic [CNT_W-1:0] EXT_TOTAL = 5'd8;
  localparam logic [CNT_W-1:0] EXT_LEN_IDX = 5'd5;
  localparam logic [CNT_W-1:0] STD_LEN_IDX = 5'd3;
  localparam logic [CNT_W-1:0] ID_FIRST_IDX = 5'd1;
  localparam logic [CNT_W-1:0] ID_LAST_IDX = 5'd4;

  typedef struct packed {
    logic        extended_frame;
    logic [31:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [15:0] repeat_interval;
    logic        send_once;
  } cmd_t;

endpackage

// ===== hdl/ccfp_parser.sv =====
// ----------------------------------------------------------------------------
// CAN command frame parser field capture
// Sorts each byte into its frame field by position and flags a finished frame.
// ----------------------------------------------------------------------------
module ccfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          byte_in,
  output logic                cmd_vld,
  output ccfp_pkg::cmd_t      cmd
);

  logic [ccfp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       ext_r, ext_nxt;
  logic                       mode_bad_r, mode_bad_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [31:0]                id_r, id_nxt;
  logic [63:0]                pay_r, pay_nxt;
  logic [7:0]                 ivl_hi_r, ivl_hi_nxt;

  logic [ccfp_pkg::CNT_W-1:0] base;
  logic [ccfp_pkg::CNT_W-1:0] off;
  logic [ccfp_pkg::CNT_W-1:0] need;
  logic [ccfp_pkg::CNT_W-1:0] cnt_inc;
  logic [7:0]                 len_now;
  logic                       check;
  logic                       bad;
  logic                       done;
  logic                       past_hdr;
  logic                       is_data;
  logic                       is_ivl_hi;
  logic [15:0]                ivl;

  always_comb begin
    cnt_inc   = cnt_r + 5'd1;
    base      = ext_r ? ccfp_pkg::EXT_BASE : ccfp_pkg::STD_BASE;
    off       = cnt_r - base;
    past_hdr  = (cnt_r >= base) && (cnt_r != '0);
    len_now   = (ext_r && cnt_r == ccfp_pkg::EXT_LEN_IDX) ? byte_in : len_r;
    check     = cnt_r >= ccfp_pkg::CHECK_IDX;
    bad       = check && (mode_bad_r || len_now > ccfp_pkg::MAX_LEN);
    need      = (ext_r ? ccfp_pkg::EXT_TOTAL : ccfp_pkg::STD_TOTAL) + {1'b0, len_now[3:0]};
    done      = check && !bad && (cnt_inc == need);
    is_data   = past_hdr && ({3'b000, off} < len_r);
    is_ivl_hi = past_hdr && ({3'b000, off} == len_r);
    ivl       = {ivl_hi_r, byte_in};
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    ext_nxt      = ext_r;
    mode_bad_nxt = mode_bad_r;
    len_nxt      = len_r;
    id_nxt       = id_r;
    pay_nxt      = pay_r;
    ivl_hi_nxt   = ivl_hi_r;
    if (byte_vld) begin
      cnt_nxt = (bad || done) ? '0 : cnt_inc;
      if (cnt_r == '0) begin
        ext_nxt      = (byte_in == ccfp_pkg::MODE_EXT);
        mode_bad_nxt = (byte_in != ccfp_pkg::MODE_EXT) && (byte_in != ccfp_pkg::MODE_STD);
        pay_nxt      = '0;
      end
      if (cnt_r >= ccfp_pkg::ID_FIRST_IDX && cnt_r <= ccfp_pkg::ID_LAST_IDX) begin
        id_nxt = {id_r[23:0], byte_in};
      end
      if ((ext_r && cnt_r == ccfp_pkg::EXT_LEN_IDX) ||
          (!ext_r && cnt_r == ccfp_pkg::STD_LEN_IDX)) begin
        len_nxt = byte_in;
      end
      for (int k = 0; k < 8; k++) begin
        if (is_data && off[2:0] == k[2:0]) begin
          pay_nxt[8*k +: 8] = byte_in;
        end
      end
      if (is_ivl_hi) begin
        ivl_hi_nxt = byte_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ext_r      <= ext_nxt;
    mode_bad_r <= mode_bad_nxt;
    len_r      <= len_nxt;
    id_r       <= id_nxt;
    pay_r      <= pay_nxt;
    ivl_hi_r   <= ivl_hi_nxt;
  end

  assign cmd_vld = byte_vld && done;

  always_comb begin
    cmd.extended_frame  = ext_r;
    cmd.frame_id        = ext_r ? id_r : {16'h0000, id_r[31:16]};
    cmd.data_length     = len_now[3:0];
    cmd.payload         = pay_r;
    cmd.repeat_interval = ivl;
    cmd.send_once       = (ivl == 16'h0000);
  end

endmodule

// ===== hdl/can_command_frame_parser_core.sv =====
// A received byte is registered on acceptance and parsed once the result side can take it.
// A finished command passes the byte register and then the result register before it shows on out_tvalid.
// One byte is accepted per cycle while the result side is not stalled.
// The byte stage and the result register set the rate; nothing iterates.
// Synchronous active-low reset empties both stages and starts a new frame.
// ----------------------------------------------------------------------------
// CAN command frame parser core
// Collects serial bytes into command frames and emits each parsed command.
// ----------------------------------------------------------------------------
module can_command_frame_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] frame_id, [35:32] data_length, [99:36] payload,
  // [115:100] repeat_interval, [116] send_once, [119:117] zero
  output logic [ccfp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic         out_tuser   // [0] extended_frame
);

  `include "can_command_frame_parser_core_defines.svh"

  logic                 in_vld_r;
  logic [7:0]           in_byte_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [ccfp_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                 out_user_r;
  logic                 adv;
  logic                 cmd_vld;
  ccfp_pkg::cmd_t       cmd;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  ccfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (adv),
    .byte_in  (in_byte_r),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && cmd_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      out_vld_r <= out_vld_nxt;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (adv && cmd_vld) begin
      out_data_r <= {3'b000, cmd.send_once, cmd.repeat_interval, cmd.payload,
                     cmd.data_length, cmd.frame_id};
      out_user_r <= cmd.extended_frame;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `CCFP_ASSERT_NEXT(a_cmd_lands, adv && cmd_vld, out_tvalid, "parsed command was not registered")
  `CCFP_ASSERT_SAME(a_len_range, out_tvalid, out_tdata[35:32] <= 4'd8, "data length above eight")
  `CCFP_ASSERT_SAME(a_once_flag, out_tvalid, out_tdata[116] == (out_tdata[115:100] == 16'h0000), "send-once flag disagrees with interval")
  `CCFP_ASSERT_SAME(a_std_id, out_tvalid && !out_tuser, out_tdata[31:16] == 16'h0000, "standard identifier wider than 16 bits")

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// CAN command frame parser testbench
// Streams well-formed standard and extended command frames, frames with a bad
// mode or an oversized length, and loose noise bytes into the parser. Random
// gaps are inserted on the byte side and random stalls on the command side.
// Every emitted command is compared field by field against a software copy of
// the frame collector.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  class frame_tracker;
    logic [7:0]       frame_bytes[16];
    logic [CNT_W-1:0] stored;
    cmd_t             pending_cmds[$];
    int               errors;
    int               dropped;
    int               checked;
    int               ext_seen;
    int               once_seen;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      stored = '0;
    endfunction

    function void take_byte(logic [7:0] b);
      cmd_t             c;
      logic [7:0]       len;
      logic [CNT_W-1:0] base;
      logic [CNT_W-1:0] need;
      bit               ext;
      if (stored < 16) frame_bytes[stored] = b;
      stored = stored + 1'b1;
      if (stored < STD_TOTAL) return;
      if (frame_bytes[0] > MODE_EXT) begin
        stored = '0;
        dropped++;
        return;
      end
      ext = (frame_bytes[0] == MODE_EXT);
      len = ext ? frame_bytes[EXT_LEN_IDX] : frame_bytes[STD_LEN_IDX];
      if (len > MAX_LEN) begin
        stored = '0;
        dropped++;
        return;
      end
      need = (ext ? EXT_TOTAL : STD_TOTAL) + len[CNT_W-1:0];
      if (stored < need) return;
      c = '0;
      c.extended_frame = ext;
      if (ext) begin
        c.frame_id = {frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4]};
        base = EXT_BASE;
      end else begin
        c.frame_id = {16'h0000, frame_bytes[1], frame_bytes[2]};
        base = STD_BASE;
      end
      for (int i = 0; i < len; i++) c.payload[8*i +: 8] = frame_bytes[base + i];
      c.data_length = len[3:0];
      c.repeat_interval = {frame_bytes[base + len], frame_bytes[base + len + 1]};
      c.send_once = (c.repeat_interval == 16'h0000);
      pending_cmds.push_back(c);
      stored = '0;
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_command(logic [OUT_DATA_W-1:0] d, logic u);
      cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: command with none expected, actual data 0x%0h ext %0b",
                 $time, d, u);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      checked++;
      if (want.extended_frame) ext_seen++;
      if (want.send_once) once_seen++;
      field_check("extended_frame", want.extended_frame, u);
      field_check("frame_id", want.frame_id, d[31:0]);
      field_check("data_length", want.data_length, d[35:32]);
      field_check("payload", want.payload, d[99:36]);
      field_check("repeat_interval", want.repeat_interval, d[115:100]);
      field_check("send_once", want.send_once, d[116]);
      field_check("padding", 64'h0, d[119:117]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  frame_tracker tracker;
  int           bytes_sent;
  bit           calm;
  bit           quiet_frame;
  int           stall_left;

  can_command_frame_parser_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d commands outstanding", tracker.pending_cmds.size());
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_tvalid && out_tready) tracker.check_command(out_tdata, out_tuser);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= (stall_left == 1);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (!calm && !quiet_frame && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    quiet_frame = ($urandom_range(0, 3) == 0);
    foreach (q[i]) push_byte(q[i]);
  endtask

  function automatic byte_q_t good_frame(bit ext, logic [31:0] id, int len,
                                         logic [63:0] pay, logic [15:0] ivl);
    byte_q_t q;
    q.push_back(ext ? MODE_EXT : MODE_STD);
    if (ext) begin
      q.push_back(id[31:24]);
      q.push_back(id[23:16]);
    end
    q.push_back(id[15:8]);
    q.push_back(id[7:0]);
    q.push_back(8'(len));
    for (int i = 0; i < len; i++) q.push_back(pay[8*i +: 8]);
    q.push_back(ivl[15:8]);
    q.push_back(ivl[7:0]);
    return q;
  endfunction

  task automatic send_random_frame();
    byte_q_t     q;
    int          kind;
    int          len;
    bit          ext;
    logic [15:0] ivl;
    kind = $urandom_range(0, 19);
    ext = $urandom_range(0, 1);
    if (kind < 15) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: len = 8;
        5, 6, 7:       len = 0;
        default:       len = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: ivl = 16'h0000;
        3, 4:    ivl = 16'hFFFF;
        default: ivl = 16'($urandom);
      endcase
      q = good_frame(ext, $urandom, len, {$urandom, $urandom}, ivl);
    end else if (kind < 17) begin
      q.push_back(8'($urandom_range(2, 255)));
      repeat (5) q.push_back(8'($urandom));
    end else if (kind < 19) begin
      q = good_frame(ext, $urandom, 0, '0, '0);
      q[ext ? EXT_LEN_IDX : STD_LEN_IDX] = 8'($urandom_range(9, 255));
      while (q.size() > 6) void'(q.pop_back());
    end else begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
    end
    send_bytes(q);
  endtask

  initial begin
    byte_q_t q;
    tracker = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    out_tready <= 1'b0;
    stall_left = 0;
    calm = 1'b0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Standard frame with an empty payload and a zero interval.
    send_bytes(good_frame(1'b0, 32'h0000FFFF, 0, '0, 16'h0000));
    // Extended frame whose length byte is one past the limit.
    q = '{MODE_EXT, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h09};
    send_bytes(q);
    // Mode byte that is neither standard nor extended.
    q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(q);
    // Standard frame with the largest length byte.
    q = '{MODE_STD, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
    send_bytes(q);
    // Full extended frame with extreme identifier and interval.
    send_bytes(good_frame(1'b1, 32'hFFFFFFFF, 8, 64'hFF00_AA55_0123_4567, 16'hFFFF));
    send_bytes(good_frame(1'b1, 32'h0000_0000, 1, 64'h80, 16'h8001));

    while (bytes_sent < 500) begin
      if (bytes_sent >= 440) calm = 1'b1;
      send_random_frame();
    end
    in_tvalid <= 1'b0;

    while (tracker.pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes; %0d frames were dropped for a bad mode or length.",
             bytes_sent, tracker.dropped);
    $display("Checked %0d commands, %0d extended and %0d with a zero interval.",
             tracker.checked, tracker.ext_seen, tracker.once_seen);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
